// File: rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types and constants for the integer literal parser: transaction
// payloads, radix and status codes, character codes.
// ----------------------------------------------------------------------------
package ilp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int PROD_WIDTH  = VALUE_WIDTH + 4;

   // Largest positive magnitude, 2^(VALUE_WIDTH-1)-1, at product width
   localparam logic [PROD_WIDTH-1:0] VALUE_MAX =
      {{(PROD_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

   // radix / base_code
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_BIN = 2'd2;
   localparam logic [1:0] RADIX_OCT = 2'd3;

   // status
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EMPTY     = 3'd1;
   localparam logic [2:0] STATUS_NO_DIGITS = 3'd2;
   localparam logic [2:0] STATUS_INVALID   = 3'd3;
   localparam logic [2:0] STATUS_RANGE     = 3'd4;

   // characters
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_UPPER_B = 8'h42;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [2:0]                    status;
      logic [1:0]                    base_code;
      logic [7:0]                    consumed;
   } rsp_payload_type;

endpackage

// File: rtl/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses one signed C-style integer literal from a character stream and
// returns value, status, base and characters consumed for each number.
// ----------------------------------------------------------------------------
// A character that ends a number shows its result in the next cycle.
// Throughput: one character per cycle; the parse state updates in a single
// pass (shift or times-ten add plus range compare) each accepted transaction.
// A one-entry result register decouples the sides; input stalls only while
// that register is full and the result side stalls.
// Reset (synchronous, active high): parser waits for a first character,
// result register empty.
module integer_literal_parser
   import ilp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_MINUS,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   // Parse state
   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [1:0]             radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   seen_ff, seen_in;
   logic [1:0]             prefix_ff, prefix_in;
   logic [7:0]             count_ff, count_in;

   // Result register
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   emit;

   // Digit decode
   logic                   is_hex;
   logic [3:0]             digit;
   logic                   digit_ok;
   logic [PROD_WIDTH-1:0]  acc_wide;
   logic [PROD_WIDTH-1:0]  product;

   // Working values inside the combinational pass
   logic                   do_take;
   logic                   do_finish;
   logic [2:0]             emit_status;
   logic [8:0]             emit_count;
   logic [8:0]             lead;
   logic [VALUE_WIDTH-1:0] emit_value;

   // Result slot is free when empty or being drained this cycle
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Hex digit decode of the incoming character
   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (req_payload.ch >= CHAR_ZERO && req_payload.ch <= CHAR_NINE) begin
         digit = 4'(req_payload.ch - CHAR_ZERO);
      end else if (req_payload.ch >= CHAR_LOWER_A && req_payload.ch <= CHAR_LOWER_F) begin
         digit = 4'(req_payload.ch - CHAR_LOWER_A + 8'd10);
      end else if (req_payload.ch >= CHAR_UPPER_A && req_payload.ch <= CHAR_UPPER_F) begin
         digit = 4'(req_payload.ch - CHAR_UPPER_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign acc_wide = {{(PROD_WIDTH-VALUE_WIDTH){1'b0}}, acc_ff};
   assign lead     = {8'd0, negative_ff} + {7'd0, prefix_ff};

   // Main parse step
   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      seen_in     = seen_ff;
      prefix_in   = prefix_ff;
      count_in    = count_ff;
      do_take     = 1'b0;
      do_finish   = 1'b0;
      emit        = 1'b0;
      emit_status = STATUS_OK;
      emit_count  = 9'd0;
      digit_ok    = 1'b0;
      product     = '0;

      case (phase_ff)
         PH_WAIT: begin
            if (req_payload.end_of_text) begin
               emit        = 1'b1;
               emit_status = STATUS_EMPTY;
               emit_count  = 9'd0;
            end else if (req_payload.ch == CHAR_MINUS) begin
               negative_in = 1'b1;
               phase_in    = PH_MINUS;
            end else if (req_payload.ch == CHAR_ZERO) begin
               phase_in = PH_ZERO;
            end else begin
               radix_in = RADIX_DEC;
               phase_in = PH_DIGITS;
               do_take  = 1'b1;
            end
         end
         PH_MINUS: begin
            if (req_payload.end_of_text) begin
               // lone minus
               emit        = 1'b1;
               emit_status = STATUS_EMPTY;
               emit_count  = {8'd0, negative_ff};
            end else if (req_payload.ch == CHAR_ZERO) begin
               phase_in = PH_ZERO;
            end else begin
               radix_in = RADIX_DEC;
               phase_in = PH_DIGITS;
               do_take  = 1'b1;
            end
         end
         PH_ZERO: begin
            if (req_payload.end_of_text) begin
               // lone zero is decimal 0
               radix_in  = RADIX_DEC;
               seen_in   = 1'b1;
               count_in  = 8'd1;
               do_finish = 1'b1;
            end else begin
               phase_in = PH_DIGITS;
               if (req_payload.ch == CHAR_LOWER_X || req_payload.ch == CHAR_UPPER_X) begin
                  radix_in  = RADIX_HEX;
                  prefix_in = 2'd2;
               end else if (req_payload.ch == CHAR_LOWER_B ||
                            req_payload.ch == CHAR_UPPER_B) begin
                  radix_in  = RADIX_BIN;
                  prefix_in = 2'd2;
               end else begin
                  // the leading zero counts as an octal digit
                  radix_in = RADIX_OCT;
                  seen_in  = 1'b1;
                  count_in = 8'd1;
                  do_take  = 1'b1;
               end
            end
         end
         PH_DIGITS: begin
            if (req_payload.end_of_text) begin
               do_finish = 1'b1;
            end else begin
               do_take = 1'b1;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase

      // Accumulate one digit in the base now in effect
      if (do_take) begin
         case (radix_in)
            RADIX_HEX: begin
               digit_ok = 1'b1;
               product  = (acc_wide << 4) + PROD_WIDTH'(digit);
            end
            RADIX_BIN: begin
               digit_ok = (digit < 4'd2);
               product  = (acc_wide << 1) + PROD_WIDTH'(digit);
            end
            RADIX_OCT: begin
               digit_ok = (digit < 4'd8);
               product  = (acc_wide << 3) + PROD_WIDTH'(digit);
            end
            default: begin
               digit_ok = (digit < 4'd10);
               product  = (acc_wide << 3) + (acc_wide << 1) + PROD_WIDTH'(digit);
            end
         endcase

         if (!is_hex) begin
            // non-hex character ends the number and is dropped
            do_finish = 1'b1;
         end else if (!digit_ok) begin
            emit        = 1'b1;
            emit_status = STATUS_INVALID;
            emit_count  = lead + {1'b0, count_in};
         end else begin
            if (!ovf_ff) begin
               if (product > VALUE_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = product[VALUE_WIDTH-1:0];
               end
            end
            seen_in = 1'b1;
            if (count_in != COUNT_MAX) begin
               count_in = count_in + 8'd1;
            end
         end
      end

      if (do_finish) begin
         emit = 1'b1;
         if (!seen_in) begin
            emit_status = STATUS_NO_DIGITS;
            emit_count  = lead;
         end else if (ovf_ff) begin
            emit_status = STATUS_RANGE;
            emit_count  = lead;
         end else begin
            emit_status = STATUS_OK;
            emit_count  = lead + {1'b0, count_in};
         end
      end

      if (emit_status == STATUS_OK) begin
         emit_value = negative_ff ? (~acc_ff + 1'b1) : acc_ff;
      end else begin
         emit_value = '0;
      end

      rsp_data_in.value     = emit_value;
      rsp_data_in.status    = emit_status;
      rsp_data_in.base_code = radix_in;
      rsp_data_in.consumed  = emit_count[8] ? COUNT_MAX : emit_count[7:0];

      // every result restarts the parser
      if (emit) begin
         phase_in    = PH_WAIT;
         negative_in = 1'b0;
         radix_in    = RADIX_DEC;
         acc_in      = '0;
         ovf_in      = 1'b0;
         seen_in     = 1'b0;
         prefix_in   = 2'd0;
         count_in    = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         negative_ff  <= 1'b0;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         prefix_ff    <= 2'd0;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept) begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            radix_ff    <= radix_in;
            acc_ff      <= acc_in;
            ovf_ff      <= ovf_in;
            seen_ff     <= seen_in;
            prefix_ff   <= prefix_in;
            count_ff    <= count_in;
            if (emit) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= rsp_data_in;
            end
         end
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_literal_parser: a text stream of directed
// corner cases, then random literals in every base plus noise, is pushed
// through the valid/stall handshake while a scoreboard predicts each parse
// result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
   import ilp_pkg::*;

   localparam int              ITEM_TARGET  = 1130;  // directed plus about 1100 random
   localparam int              HOLD_CYCLES  = 160;   // long receiver hold-off
   localparam int              STALL_LIMIT  = 2000;  // watchdog: cycles without a transaction
   localparam int              SETTLE_CYCLES = 8;    // idle wait after the last owed result
   localparam longint unsigned MAG_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

   // Parser progress within one number
   typedef enum logic [1:0] {
      AWAIT_FIRST,   // nothing of this number seen yet
      AFTER_MINUS,   // sign taken
      AFTER_ZERO,    // leading zero taken, base not decided
      IN_DIGITS      // base fixed, collecting digits
   } parse_phase_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the parse of the character stream and keeps the
   // parse results that are still owed by the block, oldest first.
   // -------------------------------------------------------------------------
   class literal_scoreboard;
      parse_phase_type phase;
      bit              negative;
      logic [1:0]      radix;
      longint unsigned accumulator;
      bit              overflowed;
      bit              digit_seen;
      int              prefix_count;
      int              digit_count;
      rsp_payload_type expected_numbers[$];
      int              errors;

      function new();
         restart();
         errors = 0;
      endfunction

      // Hex digit value of a character, 16 for anything else
      static function int digit_value(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return c - CHAR_LOWER_A + 10;
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return c - CHAR_UPPER_A + 10;
         return 16;
      endfunction

      static function int base_of(logic [1:0] r);
         case (r)
            RADIX_HEX: return 16;
            RADIX_BIN: return 2;
            RADIX_OCT: return 8;
            default:   return 10;
         endcase
      endfunction

      function void restart();
         phase        = AWAIT_FIRST;
         negative     = 1'b0;
         radix        = RADIX_DEC;
         accumulator  = 0;
         overflowed   = 1'b0;
         digit_seen   = 1'b0;
         prefix_count = 0;
         digit_count  = 0;
      endfunction

      function int pending();
         return expected_numbers.size();
      endfunction

      function void push_number(logic [2:0] status, int count);
         rsp_payload_type        item;
         logic [VALUE_WIDTH-1:0] mag;
         mag            = accumulator[VALUE_WIDTH-1:0];
         item.value     = (status == STATUS_OK) ? (negative ? -mag : mag) : '0;
         item.status    = status;
         item.base_code = radix;
         item.consumed  = (count > 255) ? COUNT_MAX : 8'(count);
         expected_numbers.push_back(item);
         restart();
      endfunction

      function void finish_number();
         int lead;
         lead = int'(negative) + prefix_count;
         if (!digit_seen)     push_number(STATUS_NO_DIGITS, lead);
         else if (overflowed) push_number(STATUS_RANGE, lead);
         else                 push_number(STATUS_OK, lead + digit_count);
      endfunction

      function void take_digit(logic [7:0] c);
         int d;
         int b;
         d = digit_value(c);
         b = base_of(radix);
         if (d >= 16) begin
            finish_number();
         end else if (d >= b) begin
            push_number(STATUS_INVALID, int'(negative) + prefix_count + digit_count);
         end else begin
            // sticky overflow freezes the accumulator, digits still checked
            if (!overflowed) begin
               if (accumulator > (MAG_MAX - d) / b) overflowed = 1'b1;
               else accumulator = accumulator * b + d;
            end
            digit_seen = 1'b1;
            if (digit_count < 255) digit_count++;
         end
      endfunction

      function void start_number(logic [7:0] c);
         if (c == CHAR_ZERO) begin
            phase = AFTER_ZERO;
         end else begin
            radix = RADIX_DEC;
            phase = IN_DIGITS;
            take_digit(c);
         end
      endfunction

      // One accepted input transaction
      function void note_char(req_payload_type p);
         case (phase)
            AWAIT_FIRST: begin
               if (p.end_of_text) push_number(STATUS_EMPTY, 0);
               else if (p.ch == CHAR_MINUS) begin
                  negative = 1'b1;
                  phase    = AFTER_MINUS;
               end else start_number(p.ch);
            end
            AFTER_MINUS: begin
               if (p.end_of_text) push_number(STATUS_EMPTY, int'(negative));
               else start_number(p.ch);
            end
            AFTER_ZERO: begin
               if (p.end_of_text) begin
                  radix       = RADIX_DEC;
                  digit_seen  = 1'b1;
                  digit_count = 1;
                  finish_number();
               end else begin
                  phase = IN_DIGITS;
                  if (p.ch == CHAR_LOWER_X || p.ch == CHAR_UPPER_X) begin
                     radix        = RADIX_HEX;
                     prefix_count = 2;
                  end else if (p.ch == CHAR_LOWER_B || p.ch == CHAR_UPPER_B) begin
                     radix        = RADIX_BIN;
                     prefix_count = 2;
                  end else begin
                     // the leading zero counts as an octal digit
                     radix       = RADIX_OCT;
                     digit_seen  = 1'b1;
                     digit_count = 1;
                     take_digit(p.ch);
                  end
               end
            end
            default: begin
               if (p.end_of_text) finish_number();
               else take_digit(p.ch);
            end
         endcase
      endfunction

      function void compare_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      // One accepted result transaction
      function void check_number(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_numbers.size() == 0) begin
            $display("%0t: unexpected result, value %0d status %0d base %0d consumed %0d",
                     $time, $signed(got.value), got.status, got.base_code, got.consumed);
            errors++;
         end else begin
            want = expected_numbers.pop_front();
            compare_field("value", $signed(want.value), $signed(got.value));
            compare_field("status", want.status, got.status);
            compare_field("base_code", want.base_code, got.base_code);
            compare_field("consumed", want.consumed, got.consumed);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   literal_scoreboard literal_sb = new();

   int items_sent    = 0;
   int idle_cycles   = 0;
   bit no_gap_run    = 1'b0;   // current number streams back to back
   bit hold_off_req  = 1'b0;   // asks the receiver for its long hold-off

   integer_literal_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor and watchdog. Everything is sampled right at the rising edge,
   // so the values seen are the ones the block saw at that edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      bit took;
      took = 1'b0;
      if (!reset) begin
         // a result never stems from a transaction accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            literal_sb.check_number(rsp_payload);
            took = 1'b1;
         end
         if (req_valid && !req_stall) begin
            literal_sb.note_char(req_payload);
            took = 1'b1;
         end
         idle_cycles = took ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall pattern, mostly short, some long, plus one long
   // hold-off on request so the result register fills and the input backs up.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int  run;
      int  pick;
      bit  hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               rsp_stall <= 1'b0;
               run = $urandom_range(1, 30);
            end else if (pick < 93) begin
               rsp_stall <= 1'b1;
               run = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               run = $urandom_range(10, 50);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender helpers
   // -------------------------------------------------------------------------
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Any character that ends a number normally
   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom);
      while (literal_scoreboard::digit_value(c) < 16);
      return c;
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_char(logic [7:0] c, bit eot);
      int gap;
      gap = no_gap_run ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{ch: c, end_of_text: eot};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   task automatic send_queue(logic [7:0] text[$]);
      foreach (text[i]) send_char(text[i], 1'b0);
   endtask

   // End of a number: end of text (with junk on ch) or a stray character
   task automatic send_terminator();
      if ($urandom_range(0, 3) == 0) send_char(8'($urandom), 1'b1);
      else send_char(non_hex_char(), 1'b0);
   endtask

   // Sender pause: drop valid and wait for every owed result
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (literal_sb.pending() != 0) @(posedge clock);
   endtask

   // Well-formed literal: optional sign, base prefix, maybe leading zeros,
   // then a magnitude that is small, 32-bit, near the positive limit or huge.
   function automatic void build_literal(ref logic [7:0] text[$]);
      longint unsigned mag;
      logic [1:0]      rad;
      logic [7:0]      digits[$];
      int              pick;
      int              zeros;
      int              d;
      int              b;
      text.delete();
      rad  = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 40)      mag = $urandom_range(0, 255);
      else if (pick < 65) mag = $urandom;
      else if (pick < 85) mag = MAG_MAX - 2 + $urandom_range(0, 4);
      else                mag = {$urandom, $urandom} >> $urandom_range(0, 32);
      if ($urandom_range(0, 1)) text.push_back(CHAR_MINUS);
      case (rad)
         RADIX_HEX: begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
         end
         RADIX_BIN: begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(0, 1) ? CHAR_LOWER_B : CHAR_UPPER_B);
         end
         RADIX_OCT: text.push_back(CHAR_ZERO);
         default: ;
      endcase
      // leading zeros in decimal would switch to octal, so only elsewhere;
      // the rare long run drives consumed into saturation
      zeros = 0;
      if (rad != RADIX_DEC) begin
         if ($urandom_range(0, 199) == 0)     zeros = 260;
         else if ($urandom_range(0, 9) == 0) zeros = $urandom_range(1, 4);
      end
      repeat (zeros) text.push_back(CHAR_ZERO);
      b = literal_scoreboard::base_of(rad);
      do begin
         d = int'(mag % b);
         digits.push_front(d < 10 ? CHAR_ZERO + 8'(d) :
            ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d - 10));
         mag = mag / b;
      end while (mag != 0);
      foreach (digits[i]) text.push_back(digits[i]);
   endfunction

   // Malformed input: random bytes, a literal with one character replaced,
   // a bare prefix, a bare sign, or just a terminator
   task automatic send_noise();
      logic [7:0] text[$];
      int         n;
      int         pos;
      case ($urandom_range(0, 4))
         0: begin
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(8'($urandom));
         end
         1: begin
            build_literal(text);
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = $urandom_range(0, 1) ? 8'($urandom) :
                        CHAR_ZERO + 8'($urandom_range(0, 9));
         end
         2: begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_B);
         end
         3: text.push_back(CHAR_MINUS);
         default: ;
      endcase
      send_queue(text);
      send_terminator();
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [7:0] text[$];
      bit         hold_started;
      bit         pause_done;
      hold_started = 1'b0;
      pause_done   = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_char(8'($urandom), 1'b1);           // empty text
      send_text("-");                          // lone minus
      send_char(8'($urandom), 1'b1);
      send_text("--");                         // second minus ends with no digits
      send_text("0");                          // lone zero at end of text
      send_char(8'($urandom), 1'b1);
      send_text("0X");                         // prefix without digits
      send_char(8'($urandom), 1'b1);
      send_text("-0xfF");                      // signed hex, top-bit terminator
      send_char(8'hFF, 1'b0);
      send_text("0b12");                       // digit too big for binary
      send_text("07");                         // octal, NUL terminator
      send_char(8'h00, 1'b0);
      send_text("0B1");
      send_char(8'($urandom), 1'b1);
      send_text("9a");                         // hex letter in decimal

      // random literals and noise
      while (items_sent < ITEM_TARGET) begin
         no_gap_run = ($urandom_range(0, 3) == 0);
         if (!hold_started && items_sent >= ITEM_TARGET / 3) begin
            hold_started = 1'b1;
            hold_off_req <= 1'b1;
         end
         if (!pause_done && items_sent >= 2 * ITEM_TARGET / 3) begin
            pause_done = 1'b1;
            wait_for_results();
         end
         if ($urandom_range(0, 4) == 0) begin
            send_noise();
         end else begin
            build_literal(text);
            send_queue(text);
            send_terminator();
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (literal_sb.errors == 0 && literal_sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
